// ===== rtl/k2s_pkg.sv =====
// ----------------------------------------------------------------------------
// k2s_pkg
// Shared types, constants and lookup functions for the key code to
// scan code set 2 sequence encoder.
// ----------------------------------------------------------------------------
package k2s_pkg;

    localparam int unsigned SINGLE_SIZE = 89;
    localparam int unsigned EXT_SIZE    = 32;

    localparam logic [7:0] CODE_SYSRQ = 8'd99;
    localparam logic [7:0] CODE_PAUSE = 8'd119;
    localparam logic [2:0] EXT_BLOCK  = 3'b011;   // codes 96..127

    localparam logic [7:0] PFX_BREAK = 8'hF0;
    localparam logic [7:0] PFX_EXT   = 8'hE0;
    localparam logic [7:0] PFX_PAUSE = 8'hE1;
    localparam logic [7:0] SC_PRTSC  = 8'h7C;
    localparam logic [7:0] SC_LSHIFT = 8'h12;
    localparam logic [7:0] SC_LCTRL  = 8'h14;
    localparam logic [7:0] SC_NUMLK  = 8'h77;

    typedef enum logic [2:0] {
        K_SINGLE_MAKE,
        K_SINGLE_BREAK,
        K_EXT_MAKE,
        K_EXT_BREAK,
        K_SYSRQ_MAKE,
        K_SYSRQ_BREAK,
        K_PAUSE_MAKE,
        K_ERROR
    } seq_kind_t;

    typedef struct packed {
        seq_kind_t  kind;
        logic [7:0] sc;
    } seq_desc_t;

    typedef struct packed {
        logic [7:0] scan_byte;
        logic       status;
        logic       last;
    } seq_beat_t;

    localparam logic [7:0] SINGLE_ROM [0:SINGLE_SIZE-1] = '{
        8'h00, 8'h76, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E,
        8'h46, 8'h45, 8'h4E, 8'h55, 8'h66, 8'h0D, 8'h15, 8'h1D, 8'h24, 8'h2D,
        8'h2C, 8'h35, 8'h3C, 8'h43, 8'h44, 8'h4D, 8'h54, 8'h5B, 8'h5A, 8'h14,
        8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h34, 8'h33, 8'h3B, 8'h42, 8'h4B, 8'h4C,
        8'h52, 8'h0E, 8'h12, 8'h5D, 8'h1A, 8'h22, 8'h21, 8'h2A, 8'h32, 8'h31,
        8'h3A, 8'h41, 8'h49, 8'h4A, 8'h59, 8'h7C, 8'h11, 8'h29, 8'h58, 8'h05,
        8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83, 8'h0A, 8'h01, 8'h09, 8'h77,
        8'h7E, 8'h6C, 8'h75, 8'h7D, 8'h7B, 8'h6B, 8'h73, 8'h74, 8'h79, 8'h69,
        8'h72, 8'h7A, 8'h70, 8'h71, 8'h00, 8'h00, 8'h61, 8'h78, 8'h07
    };

    localparam logic [7:0] EXT_ROM [0:EXT_SIZE-1] = '{
        8'h5A, 8'h14, 8'h4A, 8'h00, 8'h11, 8'h00, 8'h6C, 8'h75,
        8'h7D, 8'h6B, 8'h74, 8'h69, 8'h72, 8'h7A, 8'h70, 8'h71,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1F, 8'h27, 8'h2F
    };

    // index of the final beat for each kind
    function automatic logic [2:0] last_idx(input seq_kind_t kind);
        logic [2:0] n;
        unique case (kind)
            K_SINGLE_MAKE:  n = 3'd0;
            K_SINGLE_BREAK: n = 3'd1;
            K_EXT_MAKE:     n = 3'd1;
            K_EXT_BREAK:    n = 3'd2;
            K_SYSRQ_MAKE:   n = 3'd3;
            K_SYSRQ_BREAK:  n = 3'd5;
            K_PAUSE_MAKE:   n = 3'd7;
            default:        n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] seq_byte(input seq_desc_t d, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (d.kind)
            K_SINGLE_MAKE:  b = d.sc;
            K_SINGLE_BREAK: b = (idx == 3'd0) ? PFX_BREAK : d.sc;
            K_EXT_MAKE:     b = (idx == 3'd0) ? PFX_EXT : d.sc;
            K_EXT_BREAK: begin
                unique case (idx)
                    3'd0:    b = PFX_EXT;
                    3'd1:    b = PFX_BREAK;
                    default: b = d.sc;
                endcase
            end
            K_SYSRQ_MAKE: begin
                unique case (idx)
                    3'd0, 3'd2: b = PFX_EXT;
                    3'd1:       b = SC_LSHIFT;
                    default:    b = SC_PRTSC;
                endcase
            end
            K_SYSRQ_BREAK: begin
                unique case (idx)
                    3'd0, 3'd3: b = PFX_EXT;
                    3'd1, 3'd4: b = PFX_BREAK;
                    3'd2:       b = SC_PRTSC;
                    default:    b = SC_LSHIFT;
                endcase
            end
            K_PAUSE_MAKE: begin
                unique case (idx)
                    3'd0, 3'd3: b = PFX_PAUSE;
                    3'd1, 3'd5: b = SC_LCTRL;
                    3'd2, 3'd7: b = SC_NUMLK;
                    default:    b = PFX_BREAK;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/keycode_to_scan_set2_sequence_top.sv =====
// ----------------------------------------------------------------------------
// keycode_to_scan_set2_sequence_top
// Turns key events into PS/2 scan code set 2 byte sequences.
//
//  channel | ports                          | role
//  --------+--------------------------------+------------------------------
//  input   | s_valid s_ready s_key_code     | one key event per beat
//          | s_key_value                    |
//  output  | m_valid m_ready m_scan_byte    | one scan byte per beat,
//          | m_status m_last                | m_last on the final byte
//
// An event is classified and queued in the cycle it is accepted. The
// sequencer emits one byte per cycle while m_ready is high, so an event of
// n bytes (1 to 8) gives n beats, the first loaded once the event heads the
// queue and the output register is free. Events are taken every cycle while
// the queue has room. Reset clears only pointers, count, index and m_valid.
// ----------------------------------------------------------------------------
module keycode_to_scan_set2_sequence_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_key_code,
    input  logic [1:0] s_key_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_scan_byte,
    output logic       m_status,
    output logic       m_last
);

    k2s_pkg::seq_desc_t desc;
    k2s_pkg::seq_desc_t head;
    k2s_pkg::seq_beat_t beat;
    logic               full;
    logic               empty;
    logic               pop;

    k2s_front u_front (
        .key_code  (s_key_code),
        .key_value (s_key_value),
        .desc      (desc)
    );

    k2s_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (desc),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    k2s_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .beat    (beat)
    );

    assign s_ready     = !full;
    assign m_scan_byte = beat.scan_byte;
    assign m_status    = beat.status;
    assign m_last      = beat.last;

endmodule

// ===== rtl/k2s_front.sv =====
// ----------------------------------------------------------------------------
// k2s_front
// Classifies a key event into a sequence kind plus the looked-up scan code.
// ----------------------------------------------------------------------------
module k2s_front (
    input  logic [7:0]          key_code,
    input  logic [1:0]          key_value,
    output k2s_pkg::seq_desc_t  desc
);

    logic       press;
    logic [7:0] single_sc;
    logic [7:0] ext_sc;

    assign press = |key_value;

    always_comb begin
        if (key_code < 8'(k2s_pkg::SINGLE_SIZE)) begin
            single_sc = k2s_pkg::SINGLE_ROM[key_code[6:0]];
        end else begin
            single_sc = 8'h00;
        end
        ext_sc = k2s_pkg::EXT_ROM[key_code[4:0]];
    end

    always_comb begin
        desc.kind = k2s_pkg::K_ERROR;
        desc.sc   = 8'h00;
        priority if (key_code < 8'(k2s_pkg::SINGLE_SIZE)) begin
            desc.sc = single_sc;
            if (single_sc != 8'h00) begin
                desc.kind = press ? k2s_pkg::K_SINGLE_MAKE : k2s_pkg::K_SINGLE_BREAK;
            end
        end else if (key_code == k2s_pkg::CODE_SYSRQ) begin
            desc.kind = press ? k2s_pkg::K_SYSRQ_MAKE : k2s_pkg::K_SYSRQ_BREAK;
        end else if (key_code == k2s_pkg::CODE_PAUSE && press) begin
            desc.kind = k2s_pkg::K_PAUSE_MAKE;
        end else if (key_code[7:5] == k2s_pkg::EXT_BLOCK) begin
            desc.sc = ext_sc;
            if (ext_sc != 8'h00) begin
                desc.kind = press ? k2s_pkg::K_EXT_MAKE : k2s_pkg::K_EXT_BREAK;
            end
        end else begin
            desc.kind = k2s_pkg::K_ERROR;
        end
    end

endmodule

// ===== rtl/k2s_fifo.sv =====
// ----------------------------------------------------------------------------
// k2s_fifo
// Short descriptor queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module k2s_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  k2s_pkg::seq_desc_t  push_data,
    output logic                full,
    input  logic                pop,
    output k2s_pkg::seq_desc_t  head,
    output logic                empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    k2s_pkg::seq_desc_t mem [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/k2s_back.sv =====
// ----------------------------------------------------------------------------
// k2s_back
// Sequencer: walks the head descriptor one byte per beat into the output
// register and releases it as its final byte is loaded.
// ----------------------------------------------------------------------------
module k2s_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  k2s_pkg::seq_desc_t  head,
    input  logic                empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output k2s_pkg::seq_beat_t  beat
);

    logic               m_valid_reg, m_valid_next;
    logic [2:0]         idx_reg, idx_next;
    k2s_pkg::seq_beat_t beat_reg, beat_next;
    logic               load;
    logic               at_last;

    // output register free, or being drained this cycle
    assign load    = (!m_valid_reg || m_ready) && !empty;
    assign at_last = (idx_reg == k2s_pkg::last_idx(head.kind));
    assign pop     = load && at_last;

    always_comb begin
        m_valid_next = m_valid_reg;
        idx_next     = idx_reg;
        beat_next    = beat_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next        = 1'b1;
            beat_next.scan_byte = k2s_pkg::seq_byte(head, idx_reg);
            beat_next.status    = (head.kind == k2s_pkg::K_ERROR);
            beat_next.last      = at_last;
            idx_next            = at_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 3'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
    end

    assign m_valid = m_valid_reg;
    assign beat    = beat_reg;

endmodule
